>>> design/arsrd_pkg.sv
// ----------------------------------------------------------------------------
// arsrd_pkg
// Shared types and constants for the alpha run sprite row decoder: payload
// structs, status codes, register indexes and controller/datapath signals.
// ----------------------------------------------------------------------------
package arsrd_pkg;

    // Columns at or past this limit are never visible
    localparam int unsigned MAX_WIDTH = 4096;

    // Alpha levels selected by code bits 7:6
    localparam logic [7:0] ALPHA_NONE = 8'd0;
    localparam logic [7:0] ALPHA_LOW  = 8'd64;
    localparam logic [7:0] ALPHA_MID  = 8'd127;
    localparam logic [7:0] ALPHA_FULL = 8'd255;

    // Result status codes
    typedef enum logic [2:0] {
        ST_OK          = 3'd0,
        ST_RUN_LONG    = 3'd1,
        ST_STRAY_COLOR = 3'd2,
        ST_STRAY_CODE  = 3'd3,
        ST_FRAME_DONE  = 3'd4
    } status_t;

    // Configuration register indexes
    typedef enum logic [2:0] {
        CFG_WIN_LEFT    = 3'd0,
        CFG_WIN_RIGHT   = 3'd1,
        CFG_WIN_TOP     = 3'd2,
        CFG_WIN_BOTTOM  = 3'd3,
        CFG_IMAGE_WIDTH = 3'd4
    } cfg_index_t;

    // Input item: mode 0 carries a code byte, mode 1 a color word
    typedef struct packed {
        logic        mode;
        logic [7:0]  code_byte;
        logic [15:0] color_word;
    } in_item_t;

    // Result item
    typedef struct packed {
        logic [12:0] pixel_x;
        logic [11:0] pixel_row;
        logic [7:0]  alpha_out;
        logic [15:0] color565;
        logic        visible;
        logic        run_last;
        logic        row_end;
        status_t     status;
    } out_item_t;

    // Controller to datapath
    typedef struct packed {
        logic load_item;   // latch the accepted transaction
        logic step;        // apply one decode step
    } ctrl_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic emit;        // current step produces a result
        logic last;        // current result ends the item
        logic out_free;    // result register can take a new value
    } dp_stat_t;

    // Alpha value for a two-bit level
    function automatic logic [7:0] alpha_of(input logic [1:0] level);
        logic [7:0] a;
        case (level)
            2'd1:    a = ALPHA_LOW;
            2'd2:    a = ALPHA_MID;
            2'd3:    a = ALPHA_FULL;
            default: a = ALPHA_NONE;
        endcase
        return a;
    endfunction

endpackage

>>> design/arsrd_ctrl.sv
// ----------------------------------------------------------------------------
// arsrd_ctrl
// Sequencer: takes one transaction at a time, then steps the datapath until
// the item has produced all of its results.
// ----------------------------------------------------------------------------
module arsrd_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  arsrd_pkg::dp_stat_t  stat,
    output arsrd_pkg::ctrl_cmd_t cmd
);

    typedef enum logic [0:0] {
        IDLE = 1'b0,
        EXEC = 1'b1
    } state_t;

    state_t state_reg, state_next;
    logic   ready_reg, ready_next;

    // Commands and next state
    always_comb begin
        cmd.load_item = ready_reg && s_valid;
        cmd.step      = (state_reg == EXEC) && (!stat.emit || stat.out_free);
        state_next    = state_reg;
        case (state_reg)
            IDLE: begin
                if (cmd.load_item) begin
                    state_next = EXEC;
                end
            end
            EXEC: begin
                if (cmd.step && (!stat.emit || stat.last)) begin
                    state_next = IDLE;
                end
            end
            default: state_next = IDLE;
        endcase
        ready_next = (state_next == IDLE);
    end

    // State and registered ready
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= IDLE;
            ready_reg <= 1'b1;
        end else begin
            state_reg <= state_next;
            ready_reg <= ready_next;
        end
    end

    assign s_ready = ready_reg;

    // A transaction is only taken while no item is in flight
    a_load_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_item |-> state_reg == IDLE)
        else $error("transaction accepted while busy");

    // An item that produces no result ends in one step
    a_quiet_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == EXEC && !stat.emit) |=> state_reg == IDLE)
        else $error("silent item did not finish");

    // Ready follows the idle state
    a_ready_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        ready_reg == (state_reg == IDLE))
        else $error("ready out of step with state");

endmodule

>>> design/arsrd_dp.sv
// ----------------------------------------------------------------------------
// arsrd_dp
// Datapath: window registers, frame position, pending opaque run, item
// holding register, run counter and the result register.
// ----------------------------------------------------------------------------
module arsrd_dp (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [2:0]           cfg_index,
    input  logic [12:0]          cfg_wdata,
    input  arsrd_pkg::in_item_t  s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output arsrd_pkg::out_item_t m_data,
    input  arsrd_pkg::ctrl_cmd_t cmd,
    output arsrd_pkg::dp_stat_t  stat
);

    // Configuration
    logic [11:0] win_left_reg,    win_left_next;
    logic [12:0] win_right_reg,   win_right_next;
    logic [11:0] win_top_reg,     win_top_next;
    logic [12:0] win_bottom_reg,  win_bottom_next;
    logic [12:0] image_width_reg, image_width_next;
    logic        restart;

    // Frame state
    logic [12:0] row_reg,        row_next;
    logic [12:0] col_reg,        col_next;
    logic [5:0]  pend_cnt_reg,   pend_cnt_next;
    logic [7:0]  pend_alpha_reg, pend_alpha_next;
    logic        done_reg,       done_next;

    // Item and result registers
    arsrd_pkg::in_item_t  item_reg;
    logic [5:0]           rem_reg;
    arsrd_pkg::out_item_t out_reg, out_next;
    logic                 m_valid_reg, m_valid_next;

    // Decode signals
    logic [12:0] row_w;
    logic [12:0] col_inc;
    logic [12:0] row_inc;
    logic [12:0] room;
    logic [12:0] pix_x;
    logic        rend;
    logic        vis;
    logic [5:0]  len;
    logic [7:0]  alpha;
    logic        emit;
    logic        last;
    logic        adv;
    logic        pend_load;
    logic        pend_dec;
    logic        rem_dec;
    logic        out_load;

    // Position arithmetic
    always_comb begin
        row_w   = (win_right_reg > {1'b0, win_left_reg})
                ? win_right_reg - {1'b0, win_left_reg} : 13'd0;
        col_inc = col_reg + 13'd1;
        row_inc = row_reg + 13'd1;
        room    = row_w - col_reg;
        pix_x   = {1'b0, win_left_reg} + col_reg;
        rend    = (col_inc >= row_w);
        vis     = (pix_x < image_width_reg) && (32'(pix_x) < arsrd_pkg::MAX_WIDTH);
        len     = item_reg.code_byte[5:0];
        alpha   = arsrd_pkg::alpha_of(item_reg.code_byte[7:6]);
    end

    // Classify the current step
    always_comb begin
        emit      = 1'b1;
        last      = 1'b1;
        adv       = 1'b0;
        pend_load = 1'b0;
        pend_dec  = 1'b0;
        rem_dec   = 1'b0;
        out_next.pixel_x   = pix_x;
        out_next.pixel_row = row_reg[11:0];
        out_next.alpha_out = arsrd_pkg::ALPHA_NONE;
        out_next.color565  = 16'd0;
        out_next.visible   = 1'b0;
        out_next.run_last  = 1'b1;
        out_next.row_end   = 1'b0;
        out_next.status    = arsrd_pkg::ST_OK;
        if (done_reg) begin
            out_next.status = arsrd_pkg::ST_FRAME_DONE;
        end else if (item_reg.mode) begin
            if (pend_cnt_reg == 6'd0) begin
                out_next.status = arsrd_pkg::ST_STRAY_COLOR;
            end else begin
                // one opaque pixel per color word
                out_next.alpha_out = pend_alpha_reg;
                out_next.color565  = item_reg.color_word;
                out_next.visible   = vis;
                out_next.row_end   = rend;
                adv      = 1'b1;
                pend_dec = 1'b1;
            end
        end else if (pend_cnt_reg != 6'd0) begin
            out_next.status = arsrd_pkg::ST_STRAY_CODE;
        end else if (len == 6'd0) begin
            emit = 1'b0;
        end else if (alpha != arsrd_pkg::ALPHA_NONE) begin
            if ({7'd0, len} > room) begin
                out_next.status = arsrd_pkg::ST_RUN_LONG;
            end else begin
                emit      = 1'b0;
                pend_load = 1'b1;
            end
        end else begin
            // transparent run, one pixel per step, clipped at the row end
            last               = (rem_reg == 6'd1) || rend;
            out_next.visible   = vis;
            out_next.row_end   = rend;
            out_next.run_last  = last;
            adv     = 1'b1;
            rem_dec = 1'b1;
        end
    end

    assign out_load = cmd.step && emit;

    assign stat.emit     = emit;
    assign stat.last     = last;
    assign stat.out_free = !m_valid_reg || m_ready;

    // Configuration writes and frame state update
    always_comb begin
        win_left_next    = win_left_reg;
        win_right_next   = win_right_reg;
        win_top_next     = win_top_reg;
        win_bottom_next  = win_bottom_reg;
        image_width_next = image_width_reg;
        restart          = 1'b0;
        if (cfg_wr_en) begin
            restart = 1'b1;
            case (cfg_index)
                arsrd_pkg::CFG_WIN_LEFT:    win_left_next    = cfg_wdata[11:0];
                arsrd_pkg::CFG_WIN_RIGHT:   win_right_next   = cfg_wdata;
                arsrd_pkg::CFG_WIN_TOP:     win_top_next     = cfg_wdata[11:0];
                arsrd_pkg::CFG_WIN_BOTTOM:  win_bottom_next  = cfg_wdata;
                arsrd_pkg::CFG_IMAGE_WIDTH: image_width_next = cfg_wdata;
                default:                    restart          = 1'b0;
            endcase
        end

        row_next        = row_reg;
        col_next        = col_reg;
        pend_cnt_next   = pend_cnt_reg;
        pend_alpha_next = pend_alpha_reg;
        done_next       = done_reg;
        if (restart) begin
            row_next        = {1'b0, win_top_next};
            col_next        = 13'd0;
            pend_cnt_next   = 6'd0;
            pend_alpha_next = arsrd_pkg::ALPHA_NONE;
            done_next       = ({1'b0, win_top_next} >= win_bottom_next)
                           || (win_right_next <= {1'b0, win_left_next});
        end else if (cmd.step) begin
            if (pend_load) begin
                pend_cnt_next   = len;
                pend_alpha_next = alpha;
            end
            if (pend_dec) begin
                pend_cnt_next = pend_cnt_reg - 6'd1;
            end
            if (adv) begin
                if (rend) begin
                    col_next = 13'd0;
                    row_next = row_inc;
                    if (row_inc >= win_bottom_reg) begin
                        done_next = 1'b1;
                    end
                end else begin
                    col_next = col_inc;
                end
            end
        end

        m_valid_next = m_valid_reg;
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    // Control and configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            win_left_reg    <= 12'd0;
            win_right_reg   <= 13'd0;
            win_top_reg     <= 12'd0;
            win_bottom_reg  <= 13'd0;
            image_width_reg <= 13'd1;
            row_reg         <= 13'd0;
            col_reg         <= 13'd0;
            pend_cnt_reg    <= 6'd0;
            pend_alpha_reg  <= arsrd_pkg::ALPHA_NONE;
            done_reg        <= 1'b1;
            m_valid_reg     <= 1'b0;
        end else begin
            win_left_reg    <= win_left_next;
            win_right_reg   <= win_right_next;
            win_top_reg     <= win_top_next;
            win_bottom_reg  <= win_bottom_next;
            image_width_reg <= image_width_next;
            row_reg         <= row_next;
            col_reg         <= col_next;
            pend_cnt_reg    <= pend_cnt_next;
            pend_alpha_reg  <= pend_alpha_next;
            done_reg        <= done_next;
            m_valid_reg     <= m_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (cmd.load_item) begin
            item_reg <= s_data;
            rem_reg  <= s_data.code_byte[5:0];
        end else if (cmd.step && rem_dec) begin
            rem_reg <= rem_reg - 6'd1;
        end
        if (out_load) begin
            out_reg <= out_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

    // Column stays inside the row while the frame is open
    a_col_in_row: assert property (@(posedge aclk) disable iff (!aresetn)
        !done_reg |-> col_reg < row_w)
        else $error("column offset past row width");

    // Row stays above the window bottom while the frame is open
    a_row_in_win: assert property (@(posedge aclk) disable iff (!aresetn)
        !done_reg |-> row_reg < win_bottom_reg)
        else $error("row past window bottom");

    // Pending colors always carry a nonzero alpha
    a_pend_alpha: assert property (@(posedge aclk) disable iff (!aresetn)
        pend_cnt_reg != 6'd0 |-> pend_alpha_reg != arsrd_pkg::ALPHA_NONE)
        else $error("opaque run without alpha");

    // A result is never loaded over one still waiting
    a_out_free: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |-> (!m_valid_reg || m_ready))
        else $error("result register overwritten");

endmodule

>>> design/alpha_run_sprite_row_decoder_top.sv
// An item is latched in the item holding register; its results go out through the
// result register, and a step waits while that register holds an unaccepted result.
// A transparent run yields one pixel per step of the datapath, clipped at the row end.
// One item is decoded at a time; the result register frees the input side early.
// Reset (aresetn low, synchronous): window registers zero, image width 1, frame done,
// no pending run, result channel empty.
// ----------------------------------------------------------------------------
// alpha_run_sprite_row_decoder_top
// Decodes run-coded sprite rows inside a configured window into per-pixel
// results with alpha, raw RGB565 color, visibility and status.
// ----------------------------------------------------------------------------
module alpha_run_sprite_row_decoder_top (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [2:0]           cfg_index,
    input  logic [12:0]          cfg_wdata,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  arsrd_pkg::in_item_t  s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output arsrd_pkg::out_item_t m_data
);

    arsrd_pkg::ctrl_cmd_t cmd;
    arsrd_pkg::dp_stat_t  stat;

    // Sequencer
    arsrd_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    // Datapath
    arsrd_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cmd       (cmd),
        .stat      (stat)
    );

endmodule

>>> sim/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the alpha run sprite row decoder. A directed table
// covers reset, the window edges and every error status. Randomized phases
// follow: mostly well-formed rows of runs and color words, with some broken
// input mixed in, under several windows and handshake idle patterns. Every
// result is compared field by field with an in-bench decoder model or a table row.
// ----------------------------------------------------------------------------
module tb;

    localparam int unsigned RAND_ITEMS   = 390;
    localparam int unsigned PHASE_ITEMS  = 60;
    localparam int unsigned DRAIN_CYCLES = 8;

    // Kinds of rows in the directed table
    typedef enum logic [1:0] {
        STEP_CFG,
        STEP_PIXEL,
        STEP_FIXED
    } step_kind_t;

    typedef struct {
        step_kind_t            kind;
        arsrd_pkg::cfg_index_t idx;
        logic [12:0]           val;
        arsrd_pkg::in_item_t   stim;
        arsrd_pkg::out_item_t  want;
    } plan_step_t;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 cfg_wr_en = 1'b0;
    logic [2:0]           cfg_index = '0;
    logic [12:0]          cfg_wdata = '0;
    logic                 s_valid   = 1'b0;
    logic                 s_ready;
    arsrd_pkg::in_item_t  s_data    = '0;
    logic                 m_valid;
    logic                 m_ready   = 1'b0;
    arsrd_pkg::out_item_t m_data;

    // Decoder model: registers and frame state
    int unsigned win_l, win_r, win_t, win_b, img_w;
    int unsigned row_ctr, col_off, colors_owed;
    logic [7:0]  run_alpha;
    bit          frame_over;

    arsrd_pkg::out_item_t item_pixels[$];
    arsrd_pkg::out_item_t expected_pixels[$];
    int unsigned mismatch_count = 0;
    int unsigned src_idle_pct   = 0;
    int unsigned sink_stall_pct = 0;

    alpha_run_sprite_row_decoder_top i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Decoder model
    // ------------------------------------------------------------------
    function automatic int unsigned row_span();
        return (win_r > win_l) ? (win_r - win_l) : 0;
    endfunction

    function automatic void restart_frame();
        row_ctr     = win_t;
        col_off     = 0;
        colors_owed = 0;
        run_alpha   = arsrd_pkg::ALPHA_NONE;
        frame_over  = (win_t >= win_b) || (row_span() == 0);
    endfunction

    function automatic void model_write(input arsrd_pkg::cfg_index_t idx,
                                        input logic [12:0] val);
        case (idx)
            arsrd_pkg::CFG_WIN_LEFT:    win_l = 32'(val[11:0]);
            arsrd_pkg::CFG_WIN_RIGHT:   win_r = 32'(val);
            arsrd_pkg::CFG_WIN_TOP:     win_t = 32'(val[11:0]);
            arsrd_pkg::CFG_WIN_BOTTOM:  win_b = 32'(val);
            arsrd_pkg::CFG_IMAGE_WIDTH: img_w = 32'(val);
            default:                    return;
        endcase
        restart_frame();
    endfunction

    function automatic bit pixel_seen();
        int unsigned x;
        x = win_l + col_off;
        return (x < img_w) && (x < arsrd_pkg::MAX_WIDTH);
    endfunction

    // One column on; wraps to the next row and closes the frame past the bottom
    function automatic void step_column();
        col_off++;
        if (col_off >= row_span()) begin
            col_off = 0;
            row_ctr++;
            if (row_ctr >= win_b)
                frame_over = 1'b1;
        end
    endfunction

    function automatic void emit_pixel(input logic [7:0] alpha, input logic [15:0] color,
                                       input bit vis, input bit last, input bit rend,
                                       input arsrd_pkg::status_t st);
        arsrd_pkg::out_item_t p;
        p.pixel_x   = 13'(win_l + col_off);
        p.pixel_row = 12'(row_ctr);
        p.alpha_out = alpha;
        p.color565  = color;
        p.visible   = vis;
        p.run_last  = last;
        p.row_end   = rend;
        p.status    = st;
        item_pixels.push_back(p);
    endfunction

    // Results caused by one accepted transaction, left in item_pixels
    function automatic void decode_item(input arsrd_pkg::in_item_t stim);
        int unsigned wdt, room, len, n;
        logic [7:0]  lvl_alpha;
        wdt = row_span();
        item_pixels.delete();
        if (frame_over) begin
            emit_pixel(arsrd_pkg::ALPHA_NONE, 16'h0, 1'b0, 1'b1, 1'b0,
                       arsrd_pkg::ST_FRAME_DONE);
            return;
        end
        if (stim.mode) begin
            if (colors_owed == 0) begin
                emit_pixel(arsrd_pkg::ALPHA_NONE, 16'h0, 1'b0, 1'b1, 1'b0,
                           arsrd_pkg::ST_STRAY_COLOR);
                return;
            end
            emit_pixel(run_alpha, stim.color_word, pixel_seen(), 1'b1,
                       col_off + 1 >= wdt, arsrd_pkg::ST_OK);
            colors_owed--;
            step_column();
            return;
        end
        if (colors_owed != 0) begin
            emit_pixel(arsrd_pkg::ALPHA_NONE, 16'h0, 1'b0, 1'b1, 1'b0,
                       arsrd_pkg::ST_STRAY_CODE);
            return;
        end
        len = 32'(stim.code_byte[5:0]);
        case (stim.code_byte[7:6])
            2'd1:    lvl_alpha = arsrd_pkg::ALPHA_LOW;
            2'd2:    lvl_alpha = arsrd_pkg::ALPHA_MID;
            2'd3:    lvl_alpha = arsrd_pkg::ALPHA_FULL;
            default: lvl_alpha = arsrd_pkg::ALPHA_NONE;
        endcase
        if (len == 0)
            return;
        room = wdt - col_off;
        // Opaque run: arms the color word count, or reports a run too long for the row
        if (lvl_alpha != arsrd_pkg::ALPHA_NONE) begin
            if (len > room) begin
                emit_pixel(arsrd_pkg::ALPHA_NONE, 16'h0, 1'b0, 1'b1, 1'b0,
                           arsrd_pkg::ST_RUN_LONG);
            end else begin
                colors_owed = len;
                run_alpha   = lvl_alpha;
            end
            return;
        end
        // Transparent run, clipped at the row end
        n = (len < room) ? len : room;
        for (int unsigned i = 0; i < n; i++) begin
            emit_pixel(arsrd_pkg::ALPHA_NONE, 16'h0, pixel_seen(), i + 1 == n,
                       col_off + 1 >= wdt, arsrd_pkg::ST_OK);
            step_column();
        end
    endfunction

    // Next random transaction, shaped by where the frame currently stands
    function automatic arsrd_pkg::in_item_t pick_item();
        arsrd_pkg::in_item_t stim;
        int unsigned         room, lim, r;
        logic [1:0]          lvl;
        stim.mode       = 1'b0;
        stim.code_byte  = 8'($urandom_range(0, 255));
        stim.color_word = 16'($urandom_range(0, 65535));
        if (frame_over) begin
            stim.mode = 1'($urandom_range(0, 1));
            return stim;
        end
        // Colors owed: mostly color words, now and then a stray code
        if (colors_owed != 0) begin
            if ($urandom_range(0, 99) < 92)
                stim.mode = 1'b1;
            return stim;
        end
        room = row_span() - col_off;
        lim  = (room < 63) ? room : 63;
        r    = $urandom_range(0, 99);
        if (r < 6) begin
            stim.mode = 1'b1;
        end else if (r < 10) begin
            stim.code_byte[5:0] = 6'd0;
        end else if (r < 16) begin
            stim.code_byte[7:6] = 2'($urandom_range(1, 3));
            if (room < 63)
                stim.code_byte[5:0] = 6'($urandom_range(room + 1, 63));
        end else begin
            lvl = 2'($urandom_range(0, 3));
            stim.code_byte[7:6] = lvl;
            if (lvl == 2'd0 && $urandom_range(0, 9) == 0)
                stim.code_byte[5:0] = 6'($urandom_range(1, 63));
            else
                stim.code_byte[5:0] = 6'($urandom_range(1, lim));
        end
        return stim;
    endfunction

    // ------------------------------------------------------------------
    // Directed table rows
    // ------------------------------------------------------------------
    function automatic plan_step_t cfg_step(input arsrd_pkg::cfg_index_t idx,
                                            input int unsigned val);
        plan_step_t s;
        s.kind = STEP_CFG;
        s.idx  = idx;
        s.val  = 13'(val);
        s.stim = '0;
        s.want = '0;
        return s;
    endfunction

    function automatic plan_step_t pixel_step(input logic mode, input logic [7:0] code,
                                              input logic [15:0] color);
        plan_step_t s;
        s.kind = STEP_PIXEL;
        s.idx  = arsrd_pkg::CFG_WIN_LEFT;
        s.val  = '0;
        s.stim = {mode, code, color};
        s.want = '0;
        return s;
    endfunction

    // Error rows: one result at the given position with run_last set, everything else zero
    function automatic plan_step_t fixed_step(input logic mode, input logic [7:0] code,
                                              input logic [15:0] color, input int unsigned x,
                                              input int unsigned row,
                                              input arsrd_pkg::status_t st);
        plan_step_t s;
        s.kind           = STEP_FIXED;
        s.idx            = arsrd_pkg::CFG_WIN_LEFT;
        s.val            = '0;
        s.stim           = {mode, code, color};
        s.want           = '0;
        s.want.pixel_x   = 13'(x);
        s.want.pixel_row = 12'(row);
        s.want.run_last  = 1'b1;
        s.want.status    = st;
        return s;
    endfunction

    // ------------------------------------------------------------------
    // Driving
    // ------------------------------------------------------------------
    task automatic send_item(input arsrd_pkg::in_item_t stim, input bit has_fixed,
                             input arsrd_pkg::out_item_t want);
        while (src_idle_pct != 0 && $urandom_range(0, 99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= stim;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        decode_item(stim);
        if (has_fixed)
            expected_pixels.push_back(want);
        else
            foreach (item_pixels[i])
                expected_pixels.push_back(item_pixels[i]);
    endtask

    // Input side quiet and all results in, then a drain wait for items with no result
    task automatic wait_idle();
        s_valid <= 1'b0;
        while (expected_pixels.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input arsrd_pkg::cfg_index_t idx, input logic [12:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        model_write(idx, val);
        @(posedge aclk);
    endtask

    // Receiver stalls
    always @(posedge aclk)
        m_ready <= ($urandom_range(0, 99) >= sink_stall_pct);

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned exp);
        $display("MISMATCH at %0t: %s got %0d expected %0d", $time, what, got, exp);
        mismatch_count++;
    endtask

    always @(posedge aclk) begin : check_results
        arsrd_pkg::out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_pixels.size() == 0) begin
                report_mismatch("unexpected result, status", 32'(m_data.status), 0);
            end else begin
                want = expected_pixels.pop_front();
                if (m_data.pixel_x !== want.pixel_x)
                    report_mismatch("pixel_x", 32'(m_data.pixel_x), 32'(want.pixel_x));
                if (m_data.pixel_row !== want.pixel_row)
                    report_mismatch("pixel_row", 32'(m_data.pixel_row),
                                    32'(want.pixel_row));
                if (m_data.alpha_out !== want.alpha_out)
                    report_mismatch("alpha_out", 32'(m_data.alpha_out),
                                    32'(want.alpha_out));
                if (m_data.color565 !== want.color565)
                    report_mismatch("color565", 32'(m_data.color565), 32'(want.color565));
                if (m_data.visible !== want.visible)
                    report_mismatch("visible", 32'(m_data.visible), 32'(want.visible));
                if (m_data.run_last !== want.run_last)
                    report_mismatch("run_last", 32'(m_data.run_last), 32'(want.run_last));
                if (m_data.row_end !== want.row_end)
                    report_mismatch("row_end", 32'(m_data.row_end), 32'(want.row_end));
                if (m_data.status !== want.status)
                    report_mismatch("status", 32'(m_data.status), 32'(want.status));
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial begin
        plan_step_t          plan[$];
        arsrd_pkg::in_item_t stim;
        int unsigned         phase, done_hits, rand_items;
        int unsigned         left_col, right_col, top_row, bottom_row, img_cols, span;

        phase      = 0;
        rand_items = 0;
        win_l = 0;
        win_r = 0;
        win_t = 0;
        win_b = 0;
        img_w = 1;
        restart_frame();

        // Reset window is empty, so the frame is already done
        plan.push_back(fixed_step(1'b0, 8'h41, 16'h0000, 0, 0, arsrd_pkg::ST_FRAME_DONE));
        plan.push_back(fixed_step(1'b1, 8'hff, 16'hffff, 0, 0, arsrd_pkg::ST_FRAME_DONE));
        // Six columns at the right edge, two rows, image ends inside the window
        plan.push_back(cfg_step(arsrd_pkg::CFG_WIN_LEFT, 4090));
        plan.push_back(cfg_step(arsrd_pkg::CFG_WIN_RIGHT, 4096));
        plan.push_back(cfg_step(arsrd_pkg::CFG_WIN_TOP, 0));
        plan.push_back(cfg_step(arsrd_pkg::CFG_WIN_BOTTOM, 2));
        plan.push_back(cfg_step(arsrd_pkg::CFG_IMAGE_WIDTH, 4093));
        plan.push_back(fixed_step(1'b1, 8'h00, 16'h1234, 4090, 0,
                                  arsrd_pkg::ST_STRAY_COLOR));
        plan.push_back(fixed_step(1'b0, 8'hc7, 16'hffff, 4090, 0, arsrd_pkg::ST_RUN_LONG));
        // zero-length runs, transparent and opaque
        plan.push_back(pixel_step(1'b0, 8'h00, 16'h5a5a));
        plan.push_back(pixel_step(1'b0, 8'h80, 16'h0000));
        plan.push_back(pixel_step(1'b0, 8'h42, 16'h0000));
        plan.push_back(fixed_step(1'b0, 8'h01, 16'h0000, 4090, 0,
                                  arsrd_pkg::ST_STRAY_CODE));
        plan.push_back(pixel_step(1'b1, 8'h00, 16'hffff));
        plan.push_back(pixel_step(1'b1, 8'hff, 16'h0000));
        // longest transparent run, clipped to the rest of the row
        plan.push_back(pixel_step(1'b0, 8'h3f, 16'h0000));
        // whole second row opaque, closing the frame
        plan.push_back(pixel_step(1'b0, 8'h86, 16'h0000));
        plan.push_back(pixel_step(1'b1, 8'h00, 16'h0001));
        plan.push_back(pixel_step(1'b1, 8'h00, 16'h8000));
        plan.push_back(pixel_step(1'b1, 8'h00, 16'h7fff));
        plan.push_back(pixel_step(1'b1, 8'h00, 16'h00ff));
        plan.push_back(pixel_step(1'b1, 8'h00, 16'hff00));
        plan.push_back(pixel_step(1'b1, 8'h00, 16'haaaa));
        plan.push_back(fixed_step(1'b0, 8'h05, 16'h0000, 4090, 2,
                                  arsrd_pkg::ST_FRAME_DONE));

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (plan[i]) begin
            case (plan[i].kind)
                STEP_CFG: begin
                    wait_idle();
                    write_reg(plan[i].idx, plan[i].val);
                end
                STEP_PIXEL: send_item(plan[i].stim, 1'b0, '0);
                default:    send_item(plan[i].stim, 1'b1, plan[i].want);
            endcase
        end

        // Random phases: new window and idle pattern each time
        while (rand_items < RAND_ITEMS) begin
            wait_idle();
            if (phase == 0) begin
                left_col = 0;    right_col = 4096; top_row = 0;    bottom_row = 1;
                img_cols = 4096;
            end else if (phase == 1) begin
                left_col = 4095; right_col = 4096; top_row = 4090; bottom_row = 4096;
                img_cols = 1;
            end else begin
                left_col = ($urandom_range(0, 1) != 0) ? $urandom_range(0, 63)
                                                        : $urandom_range(0, 4095);
                span = $urandom_range(1, 24);
                right_col = left_col + span;
                if (right_col > 4096)
                    right_col = 4096;
                if ($urandom_range(0, 11) == 0)
                    right_col = $urandom_range(0, left_col);
                top_row    = $urandom_range(0, 4095);
                bottom_row = top_row + $urandom_range(1, 6);
                if (bottom_row > 4096)
                    bottom_row = 4096;
                img_cols = left_col + $urandom_range(0, span + 1);
                if ($urandom_range(0, 3) == 0)
                    img_cols = $urandom_range(1, 4096);
                if (img_cols < 1)
                    img_cols = 1;
                if (img_cols > 4096)
                    img_cols = 4096;
            end
            write_reg(arsrd_pkg::CFG_WIN_LEFT, 13'(left_col));
            write_reg(arsrd_pkg::CFG_WIN_RIGHT, 13'(right_col));
            write_reg(arsrd_pkg::CFG_WIN_TOP, 13'(top_row));
            write_reg(arsrd_pkg::CFG_WIN_BOTTOM, 13'(bottom_row));
            write_reg(arsrd_pkg::CFG_IMAGE_WIDTH, 13'(img_cols));

            case (phase % 4)
                0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
                1: begin src_idle_pct = 56; sink_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  sink_stall_pct = 56; end
                default: begin src_idle_pct = 22; sink_stall_pct = 22; end
            endcase

            // A finished frame only yields frame-done errors, so cut it short
            done_hits = 0;
            for (int unsigned k = 0;
                 k < PHASE_ITEMS && done_hits < 3 && rand_items < RAND_ITEMS; k++) begin
                stim = pick_item();
                if (frame_over)
                    done_hits++;
                rand_items++;
                send_item(stim, 1'b0, '0);
            end
            phase++;
        end

        wait_idle();
        if (mismatch_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Run limit
    initial begin
        #4000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
